### sv/free_list_heap_allocator_macros.svh
// ----------------------------------------------------------------------------
// free_list_heap_allocator_macros
// Assertion macros used by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_HEAP_ALLOCATOR_MACROS_SVH
`define FREE_LIST_HEAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FLA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FLA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg
// Defaults, request kinds and status codes of the free-list heap allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

    localparam int DEF_HEAP_BYTES      = 65536;
    localparam int DEF_HEADER_BYTES    = 48;
    localparam int DEF_MIN_SPLIT_BYTES = 16;
    localparam int DEF_ALIGN_BYTES     = 16;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_ALIGN   = 3'd2;
    localparam logic [2:0] ST_NOFIT   = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

endpackage

### sv/fla_mem.sv
// ----------------------------------------------------------------------------
// fla_mem
// Header store: one write port, one registered read port, write-first bypass.
// ----------------------------------------------------------------------------
module fla_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int W     = 67
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/free_list_heap_allocator.sv
// ----------------------------------------------------------------------------
// free_list_heap_allocator
// Allocate/release over address-ordered heap blocks with a free list.
// ----------------------------------------------------------------------------
// After reset the block is busy while it clears every entry of the header
// store. A request is taken when start is high and busy low; its result shows
// on o_done for one cycle and must be captured then. Every header access goes
// through one memory with one read and one write port. An allocate walks the
// free list block by block, then unlinks, splits and relinks the chosen block;
// a release frees its block and merges it with free neighbours. Requests
// refused at decode raise o_done in the next cycle, and busy stays low.
module free_list_heap_allocator
    import fla_pkg::*;
#(
    parameter int HEAP_BYTES      = DEF_HEAP_BYTES,
    parameter int HEADER_BYTES    = DEF_HEADER_BYTES,
    parameter int MIN_SPLIT_BYTES = DEF_MIN_SPLIT_BYTES,
    parameter int ALIGN_BYTES     = DEF_ALIGN_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        i_kind,
    input  logic [15:0] i_request_bytes,
    input  logic [15:0] i_request_alignment,
    input  logic [15:0] i_release_offset,
    input  logic        i_release_is_null,
    input  logic        i_cfg_we,
    input  logic        i_fit_policy,
    output logic        busy,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [15:0] o_payload_offset,
    output logic [16:0] o_bytes_in_use
);

    localparam int HG      = HEAP_BYTES / ALIGN_BYTES;
    localparam int AW      = $clog2(HG);
    localparam int GW      = AW + 1;
    localparam int SH      = $clog2(ALIGN_BYTES);
    localparam int HDR_G   = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int SPLIT_G = (HDR_G * ALIGN_BYTES + MIN_SPLIT_BYTES + ALIGN_BYTES - 1)
                             / ALIGN_BYTES;
    localparam int WW      = (GW > 16) ? GW + 1 : 17;
    localparam logic [GW-1:0] NIL = GW'(HG);

    typedef struct packed {
        logic          valid;
        logic          free;
        logic [GW-1:0] gran;
        logic [GW-1:0] an;
        logic [GW-1:0] ap;
        logic [GW-1:0] fn;
        logic [GW-1:0] fp;
    } t_hdr;

    localparam int REC_W = $bits(t_hdr);

    typedef enum logic [25:0] {
        S_CLR      = 26'd1 << 0,
        S_IDLE     = 26'd1 << 1,
        S_SCAN_RD  = 26'd1 << 2,
        S_SCAN_CHK = 26'd1 << 3,
        S_PATCH_RD = 26'd1 << 4,
        S_PATCH_WR = 26'd1 << 5,
        A_BRD      = 26'd1 << 6,
        A_BLD      = 26'd1 << 7,
        A_REM1     = 26'd1 << 8,
        A_REM2     = 26'd1 << 9,
        A_SPL      = 26'd1 << 10,
        A_INS      = 26'd1 << 11,
        A_FIN      = 26'd1 << 12,
        R_BRD      = 26'd1 << 13,
        R_BLD      = 26'd1 << 14,
        R_NRD      = 26'd1 << 15,
        R_NCHK     = 26'd1 << 16,
        R_NREM1    = 26'd1 << 17,
        R_NREM2    = 26'd1 << 18,
        R_NMRG     = 26'd1 << 19,
        R_PRD      = 26'd1 << 20,
        R_PCHK     = 26'd1 << 21,
        R_PMRG     = 26'd1 << 22,
        R_PWR      = 26'd1 << 23,
        R_INS      = 26'd1 << 24,
        R_BWR      = 26'd1 << 25
    } t_state;

    typedef enum logic [1:0] {
        F_FN = 2'd0,
        F_FP = 2'd1,
        F_AP = 2'd2
    } t_fld;

    // pending single-field update of one header
    typedef struct packed {
        logic [GW-1:0] addr;
        t_fld          fld;
        logic [GW-1:0] val;
        t_state        ret;
    } t_patch;

    t_state          r_state;
    t_patch          r_pt;
    logic [AW-1:0]   r_clr;
    logic [GW-1:0]   r_start;
    logic [16:0]     r_used;
    logic            r_policy;
    logic [WW-1:0]   r_want;
    logic [GW-1:0]   r_cur;
    logic [AW:0]     r_steps;
    logic [GW-1:0]   r_best;
    logic [GW-1:0]   r_bestsz;
    logic [GW-1:0]   r_ba;
    logic [GW-1:0]   r_nb;
    t_hdr            r_b;
    t_hdr            r_n;
    t_hdr            r_p;
    logic            r_done;
    logic [2:0]      r_status;
    logic [15:0]     r_off;

    logic [REC_W-1:0] w_rdata;
    t_hdr             w_rd;
    t_hdr             w_pw;
    t_hdr             w_init;
    t_hdr             w_nbrec;
    t_hdr             w_wdata;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [AW-1:0]    w_raddr;
    logic [GW-1:0]    w_left;
    logic [WW:0]      w_nbsum;
    logic             w_split;
    logic [WW-1:0]    w_sz;
    logic             w_fits;
    logic             w_take;
    logic [GW-1:0]    w_nbest;
    logic [AW:0]      w_steps_n;
    logic [15:0]      w_g;
    logic [WW-1:0]    w_rel_b;
    logic             w_rel_bad;

    assign w_rd = w_rdata;

    fla_mem #(
        .DEPTH (HG),
        .AW    (AW),
        .W     (REC_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_init       = '0;
        w_init.valid = 1'b1;
        w_init.free  = 1'b1;
        w_init.gran  = GW'(HG - HDR_G);
        w_init.an    = NIL;
        w_init.ap    = NIL;
        w_init.fn    = NIL;
        w_init.fp    = NIL;
    end

    always_comb begin
        w_pw = w_rd;
        case (r_pt.fld)
            F_FN:    w_pw.fn = r_pt.val;
            F_FP:    w_pw.fp = r_pt.val;
            default: w_pw.ap = r_pt.val;
        endcase
    end

    // split of the chosen block
    assign w_left  = r_b.gran - r_want[GW-1:0];
    assign w_nbsum = (WW+1)'(r_ba) + (WW+1)'(HDR_G) + (WW+1)'(r_want);
    assign w_split = (w_left >= GW'(SPLIT_G)) && (w_nbsum < (WW+1)'(HG));

    always_comb begin
        w_nbrec       = '0;
        w_nbrec.valid = 1'b1;
        w_nbrec.free  = 1'b1;
        w_nbrec.gran  = w_left - GW'(HDR_G);
        w_nbrec.an    = r_b.an;
        w_nbrec.ap    = r_ba;
        w_nbrec.fn    = r_start;
        w_nbrec.fp    = NIL;
    end

    // free-list scan
    assign w_sz      = WW'(w_rd.gran);
    assign w_fits    = w_sz >= r_want;
    assign w_take    = w_fits && ((r_best == NIL) || (w_rd.gran < r_bestsz));
    assign w_nbest   = w_take ? r_cur : r_best;
    assign w_steps_n = r_steps + 1'b1;

    // release address decode
    assign w_g       = i_release_offset >> SH;
    assign w_rel_b   = WW'(w_g) - WW'(HDR_G);
    assign w_rel_bad = i_release_is_null
                    || (i_release_offset[SH-1:0] != '0)
                    || (WW'(w_g) < WW'(HDR_G))
                    || (w_rel_b >= WW'(HG));

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ba[AW-1:0];
        w_wdata = r_b;
        w_raddr = r_cur[AW-1:0];
        unique case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = (r_clr == '0) ? w_init : '0;
            end
            S_SCAN_RD:  w_raddr = r_cur[AW-1:0];
            A_BRD:      w_raddr = r_ba[AW-1:0];
            R_BRD:      w_raddr = r_ba[AW-1:0];
            S_PATCH_RD: w_raddr = r_pt.addr[AW-1:0];
            S_PATCH_WR: begin
                w_we    = 1'b1;
                w_waddr = r_pt.addr[AW-1:0];
                w_wdata = w_pw;
            end
            A_SPL: begin
                w_we    = w_split;
                w_waddr = w_nbsum[AW-1:0];
                w_wdata = w_nbrec;
            end
            A_FIN: begin
                w_we         = 1'b1;
                w_wdata      = r_b;
                w_wdata.free = 1'b0;
                w_wdata.fn   = NIL;
                w_wdata.fp   = NIL;
            end
            R_NRD:  w_raddr = r_b.an[AW-1:0];
            R_NMRG: begin
                w_we          = 1'b1;
                w_waddr       = r_b.an[AW-1:0];
                w_wdata       = r_n;
                w_wdata.valid = 1'b0;
            end
            R_PRD:  w_raddr = r_b.ap[AW-1:0];
            R_PCHK: begin
                w_we          = w_rd.free;
                w_wdata       = r_b;
                w_wdata.valid = 1'b0;
            end
            R_PWR: begin
                w_we    = 1'b1;
                w_waddr = r_b.ap[AW-1:0];
                w_wdata = r_p;
            end
            R_BWR: w_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_start  <= '0;
            r_used   <= '0;
            r_policy <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_policy <= i_fit_policy;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(HG - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_off <= '0;
                        if (i_kind == KIND_ALLOC) begin
                            r_want  <= (WW'(i_request_bytes) + WW'(ALIGN_BYTES - 1)) >> SH;
                            r_best  <= NIL;
                            r_steps <= '0;
                            r_cur   <= r_start;
                            if (i_request_bytes == '0) begin
                                r_done   <= 1'b1;
                                r_status <= ST_ZERO;
                            end else if (i_request_alignment > 16'(ALIGN_BYTES)) begin
                                r_done   <= 1'b1;
                                r_status <= ST_ALIGN;
                            end else if (r_start == NIL) begin
                                r_done   <= 1'b1;
                                r_status <= ST_NOFIT;
                            end else begin
                                r_state <= S_SCAN_RD;
                            end
                        end else begin
                            r_ba <= w_rel_b[GW-1:0];
                            if (w_rel_bad) begin
                                r_done   <= 1'b1;
                                r_status <= ST_IGNORED;
                            end else begin
                                r_state <= R_BRD;
                            end
                        end
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    if (w_fits && !r_policy) begin
                        r_ba    <= r_cur;
                        r_state <= A_BRD;
                    end else if (w_take && (w_sz == r_want)) begin
                        r_ba    <= r_cur;
                        r_state <= A_BRD;
                    end else if ((w_rd.fn >= NIL) || (w_steps_n >= (AW+1)'(HG))) begin
                        if (w_nbest == NIL) begin
                            r_done   <= 1'b1;
                            r_status <= ST_NOFIT;
                            r_state  <= S_IDLE;
                        end else begin
                            r_ba    <= w_nbest;
                            r_state <= A_BRD;
                        end
                    end else begin
                        if (w_take) begin
                            r_best   <= r_cur;
                            r_bestsz <= w_rd.gran;
                        end
                        r_cur   <= w_rd.fn;
                        r_steps <= w_steps_n;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_PATCH_RD: r_state <= S_PATCH_WR;
                S_PATCH_WR: r_state <= r_pt.ret;
                A_BRD: r_state <= A_BLD;
                A_BLD: begin
                    r_b     <= w_rd;
                    r_state <= A_REM1;
                end
                A_REM1: begin
                    if (r_b.fp < NIL) begin
                        r_pt    <= '{r_b.fp, F_FN, r_b.fn, A_REM2};
                        r_state <= S_PATCH_RD;
                    end else begin
                        r_start <= r_b.fn;
                        r_state <= A_REM2;
                    end
                end
                A_REM2: begin
                    if (r_b.fn < NIL) begin
                        r_pt    <= '{r_b.fn, F_FP, r_b.fp, A_SPL};
                        r_state <= S_PATCH_RD;
                    end else begin
                        r_state <= A_SPL;
                    end
                end
                A_SPL: begin
                    if (w_split) begin
                        r_nb     <= w_nbsum[GW-1:0];
                        r_b.gran <= r_want[GW-1:0];
                        r_b.an   <= w_nbsum[GW-1:0];
                        if (r_b.an < NIL) begin
                            r_pt    <= '{r_b.an, F_AP, w_nbsum[GW-1:0], A_INS};
                            r_state <= S_PATCH_RD;
                        end else begin
                            r_state <= A_INS;
                        end
                    end else begin
                        r_state <= A_FIN;
                    end
                end
                A_INS: begin
                    r_start <= r_nb;
                    if (r_start < NIL) begin
                        r_pt    <= '{r_start, F_FP, r_nb, A_FIN};
                        r_state <= S_PATCH_RD;
                    end else begin
                        r_state <= A_FIN;
                    end
                end
                A_FIN: begin
                    r_used   <= r_used + (17'(r_b.gran) << SH);
                    r_off    <= 16'((WW'(r_ba) + WW'(HDR_G)) << SH);
                    r_done   <= 1'b1;
                    r_status <= ST_DONE;
                    r_state  <= S_IDLE;
                end
                R_BRD: r_state <= R_BLD;
                R_BLD: begin
                    if (!w_rd.valid || w_rd.free) begin
                        r_done   <= 1'b1;
                        r_status <= ST_IGNORED;
                        r_state  <= S_IDLE;
                    end else begin
                        r_b      <= w_rd;
                        r_b.free <= 1'b1;
                        r_used   <= r_used - (17'(w_rd.gran) << SH);
                        r_state  <= R_NRD;
                    end
                end
                R_NRD: r_state <= (r_b.an < NIL) ? R_NCHK : R_PRD;
                R_NCHK: begin
                    if (w_rd.free) begin
                        r_n     <= w_rd;
                        r_state <= R_NREM1;
                    end else begin
                        r_state <= R_PRD;
                    end
                end
                R_NREM1: begin
                    if (r_n.fp < NIL) begin
                        r_pt    <= '{r_n.fp, F_FN, r_n.fn, R_NREM2};
                        r_state <= S_PATCH_RD;
                    end else begin
                        r_start <= r_n.fn;
                        r_state <= R_NREM2;
                    end
                end
                R_NREM2: begin
                    if (r_n.fn < NIL) begin
                        r_pt    <= '{r_n.fn, F_FP, r_n.fp, R_NMRG};
                        r_state <= S_PATCH_RD;
                    end else begin
                        r_state <= R_NMRG;
                    end
                end
                R_NMRG: begin
                    r_b.gran <= r_b.gran + GW'(HDR_G) + r_n.gran;
                    r_b.an   <= r_n.an;
                    if (r_n.an < NIL) begin
                        r_pt    <= '{r_n.an, F_AP, r_ba, R_PRD};
                        r_state <= S_PATCH_RD;
                    end else begin
                        r_state <= R_PRD;
                    end
                end
                R_PRD: r_state <= (r_b.ap < NIL) ? R_PCHK : R_INS;
                R_PCHK: begin
                    if (w_rd.free) begin
                        r_p      <= w_rd;
                        r_p.gran <= w_rd.gran + GW'(HDR_G) + r_b.gran;
                        r_p.an   <= r_b.an;
                        r_state  <= R_PMRG;
                    end else begin
                        r_state <= R_INS;
                    end
                end
                R_PMRG: begin
                    if (r_b.an < NIL) begin
                        r_pt    <= '{r_b.an, F_AP, r_b.ap, R_PWR};
                        r_state <= S_PATCH_RD;
                    end else begin
                        r_state <= R_PWR;
                    end
                end
                R_PWR: begin
                    r_done   <= 1'b1;
                    r_status <= ST_DONE;
                    r_state  <= S_IDLE;
                end
                R_INS: begin
                    r_b.fp  <= NIL;
                    r_b.fn  <= r_start;
                    r_start <= r_ba;
                    if (r_start < NIL) begin
                        r_pt    <= '{r_start, F_FP, r_ba, R_BWR};
                        r_state <= S_PATCH_RD;
                    end else begin
                        r_state <= R_BWR;
                    end
                end
                R_BWR: begin
                    r_done   <= 1'b1;
                    r_status <= ST_DONE;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_payload_offset = r_off;
    assign o_bytes_in_use   = r_used;

endmodule

### sv/fla_chk.sv
// ----------------------------------------------------------------------------
// fla_chk
// Port-level checks of the free-list heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "free_list_heap_allocator_macros.svh"

module fla_chk
    import fla_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [2:0]  o_status,
    input logic [15:0] o_payload_offset,
    input logic [16:0] o_bytes_in_use
);

    `FLA_ASSERT_NXT(a_accept_done, i_clk, i_rst_n, start && !busy && !o_done, o_done || busy, "accepted transfer lost")
    `FLA_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result while busy")
    `FLA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_done && (o_status != ST_DONE), o_payload_offset == '0, "offset on refused transfer")
    `FLA_ASSERT_NXT(a_used_stable, i_clk, i_rst_n, !busy && !start, $stable(o_bytes_in_use), "usage changed while idle")

endmodule

bind free_list_heap_allocator fla_chk u_fla_chk (.*);

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for free_list_heap_allocator. A behavioral heap model
// predicts the status, payload offset and byte count of every transfer.
// Directed tests cover refusals, bad and double releases, splits, merges and
// best fit. Random traffic then runs under both fit policies with varied
// sender idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import fla_pkg::*;

    localparam int GRANULES   = DEF_HEAP_BYTES / DEF_ALIGN_BYTES;
    localparam int HDR_G      = (DEF_HEADER_BYTES + DEF_ALIGN_BYTES - 1) / DEF_ALIGN_BYTES;
    localparam int NIL        = GRANULES;
    localparam int CYCLE_CAP  = 4000000;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] offset;
        logic [16:0] in_use;
    } t_heap_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        i_kind;
    logic [15:0] i_request_bytes;
    logic [15:0] i_request_alignment;
    logic [15:0] i_release_offset;
    logic        i_release_is_null;
    logic        i_cfg_we;
    logic        i_fit_policy;
    logic        busy;
    logic        o_done;
    logic [2:0]  o_status;
    logic [15:0] o_payload_offset;
    logic [16:0] o_bytes_in_use;

    free_list_heap_allocator dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .i_kind              (i_kind),
        .i_request_bytes     (i_request_bytes),
        .i_request_alignment (i_request_alignment),
        .i_release_offset    (i_release_offset),
        .i_release_is_null   (i_release_is_null),
        .i_cfg_we            (i_cfg_we),
        .i_fit_policy        (i_fit_policy),
        .busy                (busy),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_payload_offset    (o_payload_offset),
        .o_bytes_in_use      (o_bytes_in_use)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // heap model
    logic [12:0] blk_len   [GRANULES];
    bit          blk_free  [GRANULES];
    logic [12:0] addr_nxt  [GRANULES];
    logic [12:0] addr_prv  [GRANULES];
    logic [12:0] free_nxt  [GRANULES];
    logic [12:0] free_prv  [GRANULES];
    bit          hdr_live  [GRANULES];
    bit          hdr_seen  [GRANULES];
    logic [12:0] free_head;
    logic [16:0] used_bytes;
    bit          best_fit;

    t_heap_result pending_results[$];
    int           live_offsets[$];
    int           freed_offsets[$];
    int           mismatches;
    int           cycles;
    bit           start_up;

    function automatic void heap_reset();
        for (int g = 0; g < GRANULES; g++) begin
            hdr_live[g] = 1'b0;
            hdr_seen[g] = 1'b0;
        end
        blk_len[0]  = 13'(GRANULES - HDR_G);
        blk_free[0] = 1'b1;
        hdr_live[0] = 1'b1;
        hdr_seen[0] = 1'b1;
        addr_nxt[0] = 13'(NIL);
        addr_prv[0] = 13'(NIL);
        free_nxt[0] = 13'(NIL);
        free_prv[0] = 13'(NIL);
        free_head   = '0;
        used_bytes  = '0;
        best_fit    = 1'b0;
    endfunction

    function automatic void free_push(int b);
        free_prv[b] = 13'(NIL);
        free_nxt[b] = free_head;
        if (free_head < NIL) free_prv[free_head] = 13'(b);
        free_head = 13'(b);
    endfunction

    function automatic void free_unlink(int b);
        int p;
        int n;
        p = free_prv[b];
        n = free_nxt[b];
        if (p < NIL) free_nxt[p] = 13'(n);
        else free_head = 13'(n);
        if (n < NIL) free_prv[n] = 13'(p);
        free_nxt[b] = 13'(NIL);
        free_prv[b] = 13'(NIL);
    endfunction

    function automatic int pick_block(int want);
        int pick;
        int b;
        int steps;
        pick  = NIL;
        b     = free_head;
        steps = 0;
        while (b < NIL && steps < GRANULES) begin
            steps++;
            if (blk_len[b] >= want) begin
                if (!best_fit) return b;
                if (pick == NIL || blk_len[b] < blk_len[pick]) begin
                    pick = b;
                    if (blk_len[b] == want) break;
                end
            end
            b = free_nxt[b];
        end
        return pick;
    endfunction

    function automatic logic [2:0] heap_alloc(int bytes, int align, output int off);
        int want;
        int b;
        int left;
        int nb;
        off = 0;
        if (bytes == 0) return ST_ZERO;
        if (align > DEF_ALIGN_BYTES) return ST_ALIGN;
        want = (bytes + DEF_ALIGN_BYTES - 1) / DEF_ALIGN_BYTES;
        b = pick_block(want);
        if (b >= NIL) return ST_NOFIT;
        free_unlink(b);
        left = blk_len[b] - want;
        nb   = b + HDR_G + want;
        if (left * DEF_ALIGN_BYTES >= HDR_G * DEF_ALIGN_BYTES + DEF_MIN_SPLIT_BYTES
                && nb < NIL) begin
            blk_len[nb]  = 13'(left - HDR_G);
            blk_free[nb] = 1'b1;
            hdr_live[nb] = 1'b1;
            hdr_seen[nb] = 1'b1;
            addr_nxt[nb] = addr_nxt[b];
            addr_prv[nb] = 13'(b);
            if (addr_nxt[b] < NIL) addr_prv[addr_nxt[b]] = 13'(nb);
            addr_nxt[b] = 13'(nb);
            blk_len[b]  = 13'(want);
            free_push(nb);
        end
        blk_free[b] = 1'b0;
        used_bytes  = used_bytes + 17'(blk_len[b] * DEF_ALIGN_BYTES);
        off = (b + HDR_G) * DEF_ALIGN_BYTES;
        return ST_DONE;
    endfunction

    function automatic logic [2:0] heap_release(int off, bit is_null);
        int b;
        int n;
        int p;
        if (is_null) return ST_IGNORED;
        if (off % DEF_ALIGN_BYTES != 0 || off / DEF_ALIGN_BYTES < HDR_G) return ST_IGNORED;
        b = off / DEF_ALIGN_BYTES - HDR_G;
        if (b >= NIL || !hdr_live[b] || blk_free[b]) return ST_IGNORED;
        used_bytes  = used_bytes - 17'(blk_len[b] * DEF_ALIGN_BYTES);
        blk_free[b] = 1'b1;
        n = addr_nxt[b];
        if (n < NIL && blk_free[n]) begin
            free_unlink(n);
            blk_len[b]  = blk_len[b] + 13'(HDR_G) + blk_len[n];
            addr_nxt[b] = addr_nxt[n];
            if (addr_nxt[n] < NIL) addr_prv[addr_nxt[n]] = 13'(b);
            hdr_live[n] = 1'b0;
        end
        p = addr_prv[b];
        if (p < NIL && blk_free[p]) begin
            blk_len[p]  = blk_len[p] + 13'(HDR_G) + blk_len[b];
            addr_nxt[p] = addr_nxt[b];
            if (addr_nxt[b] < NIL) addr_prv[addr_nxt[b]] = 13'(p);
            hdr_live[b] = 1'b0;
            return ST_DONE;
        end
        free_push(b);
        return ST_DONE;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_heap_result want_res;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("unexpected result: status %0d offset %0d in_use %0d",
                             o_status, o_payload_offset, o_bytes_in_use);
            end else begin
                want_res = pending_results.pop_front();
                if (o_status !== want_res.status || o_payload_offset !== want_res.offset
                        || o_bytes_in_use !== want_res.in_use) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("result diff: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 want_res.status, want_res.offset, want_res.in_use,
                                 o_status, o_payload_offset, o_bytes_in_use);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("free_list_heap_allocator: mismatch");
            $finish;
        end
    end

    task automatic transfer(bit kind, int bytes, int align, int off, bit is_null,
                            output logic [2:0] st, output int grant);
        t_heap_result res;
        start               <= 1'b1;
        start_up             = 1'b1;
        i_kind              <= kind;
        i_request_bytes     <= 16'(bytes);
        i_request_alignment <= 16'(align);
        i_release_offset    <= 16'(off);
        i_release_is_null   <= is_null;
        do @(posedge i_clk); while (busy);
        grant = 0;
        if (kind == KIND_ALLOC) st = heap_alloc(bytes & 16'hFFFF, align & 16'hFFFF, grant);
        else st = heap_release(off & 16'hFFFF, is_null);
        res.status = st;
        res.offset = 16'(grant);
        res.in_use = used_bytes;
        pending_results.push_back(res);
        if (kind == KIND_ALLOC && st == ST_DONE) live_offsets.push_back(grant);
    endtask

    task automatic lower_start();
        if (start_up) begin
            start   <= 1'b0;
            start_up = 1'b0;
        end
    endtask

    task automatic sender_gap(int pct);
        int n;
        n = 0;
        while ($urandom_range(99) < pct) n++;
        if (n > 0) begin
            lower_start();
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        lower_start();
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic set_fit_policy(bit v);
        drain();
        i_cfg_we     <= 1'b1;
        i_fit_policy <= v;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        best_fit      = v;
    endtask

    task automatic alloc(int bytes, int align, output int grant);
        logic [2:0] st;
        transfer(KIND_ALLOC, bytes, align, $urandom, $urandom_range(1), st, grant);
    endtask

    task automatic release_at(int off, bit is_null);
        logic [2:0] st;
        int grant;
        transfer(KIND_RELEASE, $urandom, $urandom, off, is_null, st, grant);
        if (st == ST_DONE) begin
            for (int i = 0; i < live_offsets.size(); i++)
                if (live_offsets[i] == off) begin
                    live_offsets.delete(i);
                    break;
                end
            freed_offsets.push_back(off);
            if (freed_offsets.size() > 8) void'(freed_offsets.pop_front());
        end
    endtask

    task automatic test_refusals_and_bad_releases();
        int a;
        int b;
        int c;
        int d;
        alloc(0, 0, a);
        alloc(16, 17, a);
        alloc(16'hFFFF, 16'hFFFF, a);
        alloc(16'hFFFF, DEF_ALIGN_BYTES, a);
        alloc(GRANULES * DEF_ALIGN_BYTES - DEF_HEADER_BYTES, 0, a);
        alloc(1, 0, b);
        release_at(a, 1'b0);
        alloc(1, 0, a);
        alloc(100, DEF_ALIGN_BYTES, b);
        alloc(16, 1, c);
        alloc(48, 8, d);
        release_at(b, 1'b1);
        release_at(a + 8, 1'b0);
        release_at(32, 1'b0);
        release_at(b, 1'b0);
        release_at(b, 1'b0);
        release_at(d, 1'b0);
        release_at(c, 1'b0);
        release_at(a, 1'b0);
        drain();
    endtask

    task automatic test_best_fit();
        int e;
        int f;
        int g;
        int h;
        set_fit_policy(1'b1);
        alloc(64, 0, e);
        alloc(16, 0, f);
        alloc(32, 0, g);
        alloc(16, 0, h);
        release_at(e, 1'b0);
        release_at(g, 1'b0);
        alloc(32, 0, g);
        alloc(20, 0, e);
        release_at(f, 1'b0);
        release_at(h, 1'b0);
        drain();
    endtask

    task automatic run_mixed_traffic(int count, int idle_pct);
        int r;
        int sz;
        int al;
        int off;
        int grant;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (live_offsets.size() > 60) r = r + 30;
            if (live_offsets.size() == 0) r = 0;
            if (r < 50) begin
                case ($urandom_range(19))
                    0:       sz = $urandom_range(16'hFFFF);
                    1:       sz = 0;
                    2, 3, 4: sz = $urandom_range(4096, 257);
                    default: sz = $urandom_range(256, 1);
                endcase
                al = ($urandom_range(19) == 0) ? $urandom_range(16'hFFFF)
                                               : $urandom_range(DEF_ALIGN_BYTES);
                alloc(sz, al, grant);
            end else begin
                case ($urandom_range(19))
                    0: release_at($urandom, 1'b1);
                    1: begin
                        off = $urandom_range(16'hFFFF);
                        if (off % DEF_ALIGN_BYTES == 0 && off >= DEF_HEADER_BYTES
                                && !hdr_seen[off / DEF_ALIGN_BYTES - HDR_G])
                            off = off | 1;
                        release_at(off, 1'b0);
                    end
                    2: begin
                        if (freed_offsets.size() != 0)
                            off = freed_offsets[$urandom_range(freed_offsets.size() - 1)];
                        else
                            off = 8;
                        release_at(off, 1'b0);
                    end
                    default:
                        release_at(live_offsets[$urandom_range(live_offsets.size() - 1)],
                                   1'b0);
                endcase
            end
            sender_gap(idle_pct);
        end
        drain();
    endtask

    initial begin
        i_rst_n             = 1'b0;
        start               = 1'b0;
        i_kind              = KIND_ALLOC;
        i_request_bytes     = '0;
        i_request_alignment = '0;
        i_release_offset    = '0;
        i_release_is_null   = 1'b0;
        i_cfg_we            = 1'b0;
        i_fit_policy        = 1'b0;
        mismatches          = 0;
        cycles              = 0;
        start_up            = 1'b0;
        heap_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_fit_policy(1'b0);
        test_refusals_and_bad_releases();
        test_best_fit();
        set_fit_policy(1'b0);
        run_mixed_traffic(460, 0);
        set_fit_policy(1'b1);
        run_mixed_traffic(460, 88);
        set_fit_policy(1'b0);
        run_mixed_traffic(460, 22);
        set_fit_policy(1'b1);
        run_mixed_traffic(460, 0);

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("free_list_heap_allocator: match");
        end else begin
            $display("free_list_heap_allocator: mismatch");
        end
        $finish;
    end

endmodule

### free_list_heap_allocator.f
+incdir+sv
sv/fla_pkg.sv
sv/fla_mem.sv
sv/free_list_heap_allocator.sv
sv/fla_chk.sv
verif/tb_top.sv
